>>> src/tfi_pkg.sv
// package with shared constants and types for the table interpolator
`timescale 1ns / 1ps
`default_nettype none
package tfi_pkg;
	localparam int MaxRowsDefault    = 8192;
	localparam int NumColumnsDefault = 9;
	localparam int FracBitsDefault   = 16;
	localparam logic [13:0] RowsReset = 14'd5000;

	localparam logic [1:0] StatusOk      = 2'd0;
	localparam logic [1:0] StatusBadPair = 2'd1;
	localparam logic [1:0] StatusZeroDx  = 2'd2;

	localparam logic ActionWrite = 1'b0;
	localparam logic ActionQuery = 1'b1;

	typedef struct packed {
		logic        action;
		logic [3:0]  entry_column;
		logic [12:0] entry_row;
		logic [31:0] entry_value;
		logic [3:0]  key_column;
		logic [3:0]  result_column;
		logic [31:0] query_key;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [1:0]  status;
	} rsp_t;
endpackage
`default_nettype wire

>>> src/tfi_if.sv
// valid/ready channel interface carrying one payload
`timescale 1ns / 1ps
`default_nettype none
interface tfi_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/tfi_divider.sv
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tfi_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [32:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [63:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [33:0] shifted;
	logic [34:0] trial;

	assign shifted  = {rem_q[32:0], quo_q[63]};
	assign trial    = {1'b0, shifted} - {2'b00, div_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> src/tabulated_function_interpolator.sv
// top level: table memory, binary search sequencer and interpolation datapath
// result timing: the result register loads at the accepting edge for a write; a query runs
// the search (at most 13 probes for 8192 rows), four table reads, a product and the divider
// a bad column pair answers in the cycle after acceptance, a zero-width interval after the reads
// throughput: one request at a time; the next is taken the cycle after the result leaves
// reset: control state cleared, rows_in_use set to 5000; table contents undefined
`timescale 1ns / 1ps
`default_nettype none
module tabulated_function_interpolator #(
	parameter int MAX_ROWS    = tfi_pkg::MaxRowsDefault,
	parameter int NUM_COLUMNS = tfi_pkg::NumColumnsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [13:0] cfg_wdata,
	tfi_if.sink              req,
	tfi_if.source            rsp
);
	import tfi_pkg::*;

	localparam int RowW  = $clog2(MAX_ROWS);
	localparam int ColW  = $clog2(NUM_COLUMNS);
	localparam int Depth = NUM_COLUMNS * MAX_ROWS;
	localparam int AddrW = $clog2(Depth);
	localparam int CntW  = RowW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_SREAD, S_SWAIT, S_RX1, S_RX2, S_RY1, S_RY2, S_WAITY2,
		S_PROD, S_MUL, S_DIV, S_DONE, S_OUT
	} state_t;

	logic [31:0] mem [Depth];
	logic [31:0] rd_q;
	logic        mem_re;
	logic [AddrW-1:0] rd_addr;

	state_t      state_q;
	logic [13:0] rows_cfg_q;
	req_t        r_q;
	logic [CntW-1:0] lo_q, hi_q;
	logic signed [32:0] x1_q, x2_q, y1_q;
	logic [31:0] dy_abs_q, dq_abs_q;
	logic [63:0] prod_q;
	logic        neg_q;
	logic [32:0] dx_abs_q;
	logic        div_start;
	logic        div_done;
	logic [63:0] div_quo;
	rsp_t        out_q;
	logic        out_valid_q;

	logic [CntW-1:0] rows_c;
	logic [CntW-1:0] mid;
	logic            pair_ok;
	logic [CntW-1:0] rd_row;
	logic [3:0]      rd_col;
	logic signed [32:0] key_x, rd_x;

	assign mid  = CntW'((({1'b0, lo_q}) + ({1'b0, hi_q})) >> 1);
	assign rd_x = {rd_q[31], rd_q};
	assign key_x = {r_q.query_key[31], r_q.query_key};

	always_comb begin
		if (rows_cfg_q < 14'd2) rows_c = CntW'(2);
		else if ({18'd0, rows_cfg_q} > 32'(MAX_ROWS)) rows_c = CntW'(MAX_ROWS);
		else rows_c = CntW'(rows_cfg_q);
	end

	always_comb begin
		logic kok, vok;
		kok = (r_q.key_column == 4'd0) || (r_q.key_column == 4'd6);
		vok = (r_q.result_column >= 4'd1 && r_q.result_column <= 4'd5)
			|| r_q.result_column == 4'd7 || r_q.result_column == 4'd8;
		pair_ok = kok && vok && ({28'd0, r_q.key_column} < 32'(NUM_COLUMNS))
			&& ({28'd0, r_q.result_column} < 32'(NUM_COLUMNS));
	end

	// read address for each state
	always_comb begin
		rd_col = r_q.key_column;
		rd_row = mid;
		mem_re = 1'b0;
		unique case (state_q)
			S_SREAD: mem_re = 1'b1;
			S_RX1: begin
				mem_re = 1'b1;
				rd_row = lo_q;
			end
			S_RX2: begin
				mem_re = 1'b1;
				rd_row = lo_q + CntW'(1);
			end
			S_RY1: begin
				mem_re = 1'b1;
				rd_row = lo_q;
				rd_col = r_q.result_column;
			end
			S_RY2: begin
				mem_re = 1'b1;
				rd_row = lo_q + CntW'(1);
				rd_col = r_q.result_column;
			end
			default: mem_re = 1'b0;
		endcase
		rd_addr = AddrW'(rd_col[ColW-1:0] * MAX_ROWS + rd_row[RowW-1:0]);
	end

	function automatic logic r_in_write();
		return req.payload.action == ActionWrite;
	endfunction

	always_ff @(posedge clk) begin
		if (req.valid && req.ready && r_in_write()
			&& ({28'd0, req.payload.entry_column} < 32'(NUM_COLUMNS))
			&& ({19'd0, req.payload.entry_row} < 32'(MAX_ROWS)))
			mem[AddrW'(req.payload.entry_column[ColW-1:0] * MAX_ROWS
				+ RowW'(req.payload.entry_row))] <= req.payload.entry_value;
		if (mem_re) rd_q <= mem[rd_addr];
	end

	tfi_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_q),
		.divisor (dx_abs_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign div_start = (state_q == S_MUL);
	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [33:0] dy, dq, dx;
		logic [33:0] q;
		logic signed [34:0] r;
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_cfg_q  <= RowsReset;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) rows_cfg_q <= cfg_wdata;
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					r_q <= req.payload;
					if (req.payload.action == ActionWrite) begin
						out_q       <= '{result_value: '0, status: StatusOk};
						out_valid_q <= 1'b1;
					end else begin
						state_q <= S_SREAD;
						lo_q    <= '0;
						hi_q    <= '0;
					end
				end
				S_SREAD: begin
					if (hi_q == '0 && lo_q == '0) begin
						// first visit: check pair and set bounds
						if (!pair_ok) begin
							out_q       <= '{result_value: '0, status: StatusBadPair};
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							hi_q <= rows_c - CntW'(1);
							state_q <= (rows_c == CntW'(2)) ? S_RX1 : S_SREAD;
						end
					end else state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (rd_x == key_x) begin
						lo_q <= mid;
						state_q <= S_RX1;
					end else begin
						if (rd_x > key_x) hi_q <= mid;
						else lo_q <= mid;
						if ((rd_x > key_x ? mid - lo_q : hi_q - mid) > CntW'(1))
							state_q <= S_SREAD;
						else state_q <= S_RX1;
					end
				end
				S_RX1: state_q <= S_RX2;
				S_RX2: begin
					x1_q    <= rd_x;
					state_q <= S_RY1;
				end
				S_RY1: begin
					x2_q    <= rd_x;
					state_q <= S_RY2;
				end
				S_RY2: begin
					y1_q    <= rd_x;
					state_q <= S_WAITY2;
				end
				S_WAITY2: begin
					dy = 34'(rd_x) - 34'(y1_q);
					dq = 34'(key_x) - 34'(x1_q);
					dx = 34'(x2_q) - 34'(x1_q);
					if (x1_q == x2_q) begin
						out_q       <= '{result_value: '0, status: StatusZeroDx};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						neg_q    <= (dy[33] ^ dq[33]) ^ dx[33];
						dy_abs_q <= 32'(dy[33] ? -dy : dy);
						dq_abs_q <= 32'(dq[33] ? -dq : dq);
						dx_abs_q <= 33'(dx[33] ? -dx : dx);
						state_q  <= S_PROD;
					end
				end
				// magnitudes are below 2^32, so one 32x32 product
				S_PROD: begin
					prod_q  <= 64'(dy_abs_q) * 64'(dq_abs_q);
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: if (div_done) state_q <= S_DONE;
				S_DONE: begin
					q = (div_quo > 64'h2_0000_0000) ? 34'h2_0000_0000 : div_quo[33:0];
					r = neg_q ? 35'(y1_q) - 35'(q) : 35'(y1_q) + 35'(q);
					if (r > 35'sh7FFF_FFFF) out_q.result_value <= 32'h7FFF_FFFF;
					else if (r < -35'sh8000_0000) out_q.result_value <= 32'h8000_0000;
					else out_q.result_value <= r[31:0];
					out_q.status <= StatusOk;
					out_valid_q  <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
